// ----- rtl/btop_pkg.sv -----
`timescale 1ns / 1ps
package btop_pkg;
   localparam int unsigned MAX_STEPS_DEFAULT = 255;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   typedef enum logic [2:0] {
      CSR_STRIKE   = 3'd0,
      CSR_UP       = 3'd1,
      CSR_DOWN     = 3'd2,
      CSR_PROB     = 3'd3,
      CSR_DISC     = 3'd4,
      CSR_STEPS    = 3'd5,
      CSR_IS_PUT   = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEAF_MUL,
      ST_LEAF_TAKE,
      ST_LEAF_STORE,
      ST_FOLD_RD0,
      ST_FOLD_RD1,
      ST_FOLD_MUL_Q,
      ST_FOLD_MUL_D,
      ST_FOLD_STORE,
      ST_ZERO,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_spot;   // capture the spot, x := spot, clear the flag
      logic leaf_mul;    // prod := x * factor
      logic use_down;    // factor select for leaf_mul
      logic leaf_take;   // x := sat(prod >> 30)
      logic leaf_store;  // write payoff of x at node address, x := captured spot
      logic rd_hi;       // read node i+1 instead of node i
      logic mul_p;       // acc := p * v[i]
      logic mul_q;       // acc += q * v[i+1]
      logic mul_d;       // prod := (acc>>30) * disc
      logic fold_store;  // write prod>>30 at node i
      logic zero_steps;  // N = 0: take payoff directly
   } dp_cmd_type;
endpackage

// ----- rtl/btop_ram.sv -----
`timescale 1ns / 1ps
module btop_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/btop_datapath.sv -----
`timescale 1ns / 1ps
module btop_datapath #(
   parameter int unsigned MAX_STEPS = btop_pkg::MAX_STEPS_DEFAULT,
   localparam int unsigned AW = $clog2(MAX_STEPS + 1)
) (
   input  logic                 clock,
   input  btop_pkg::dp_cmd_type cmd,
   input  logic [AW-1:0]        node_addr,
   input  logic [31:0]          spot,
   input  logic [31:0]          strike,
   input  logic [31:0]          up_factor,
   input  logic [31:0]          down_factor,
   input  logic [30:0]          prob,
   input  logic [30:0]          disc,
   input  logic                 is_put,
   output logic [31:0]          root_value,
   output logic                 sat_flag
);
   logic [31:0] spot_ff, spot_in;
   logic [31:0] x_ff, x_in;
   logic        sat_ff, sat_in;
   logic [63:0] prod_ff, prod_in;
   logic [62:0] acc_ff, acc_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_r;
   logic [31:0] payoff;
   logic [31:0] ram_rd;
   logic        ram_we;
   logic [31:0] ram_wd;
   logic [AW-1:0] rd_addr;
   logic [30:0] prob_c;
   logic [30:0] q_c;
   logic [30:0] disc_c;
   logic [33:0] leaf_shift;
   logic [31:0] leaf_x;
   logic        leaf_sat;

   assign prob_c = (prob > btop_pkg::ONE_Q30) ? btop_pkg::ONE_Q30 : prob;
   assign q_c    = btop_pkg::ONE_Q30 - prob_c;
   assign disc_c = (disc > btop_pkg::ONE_Q30) ? btop_pkg::ONE_Q30 : disc;

   // One shared 32 x 32 multiplier serves leaf and fold products.
   always_comb begin
      mul_a = x_ff;
      mul_b = cmd.use_down ? down_factor : up_factor;
      if (cmd.mul_p) begin
         mul_a = ram_rd;
         mul_b = {1'b0, prob_c};
      end else if (cmd.mul_q) begin
         mul_a = ram_rd;
         mul_b = {1'b0, q_c};
      end else if (cmd.mul_d) begin
         mul_a = acc_ff[61:30];
         mul_b = {1'b0, disc_c};
      end
   end
   assign mul_r = mul_a * mul_b;

   assign leaf_shift = prod_ff[63:30];
   assign leaf_sat   = |leaf_shift[33:32];
   assign leaf_x     = leaf_sat ? 32'hFFFF_FFFF : leaf_shift[31:0];

   always_comb begin
      if (is_put) begin
         payoff = (strike > x_ff) ? strike - x_ff : 32'd0;
      end else begin
         payoff = (x_ff > strike) ? x_ff - strike : 32'd0;
      end
   end

   always_comb begin
      spot_in = spot_ff;
      x_in    = x_ff;
      sat_in  = sat_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      root_in = root_ff;
      if (cmd.load_spot) begin
         spot_in = spot;
         x_in    = spot;
         sat_in  = 1'b0;
      end
      if (cmd.leaf_take) begin
         x_in   = leaf_x;
         sat_in = sat_ff | leaf_sat;
      end
      // Each leaf starts again from the spot captured at the transfer.
      if (cmd.leaf_store) begin
         x_in = spot_ff;
      end
      if (cmd.leaf_mul || cmd.mul_d) begin
         prod_in = mul_r;
      end
      if (cmd.mul_p) begin
         acc_in = mul_r[62:0];
      end
      if (cmd.mul_q) begin
         acc_in = acc_ff + mul_r[62:0];
      end
      if (cmd.zero_steps) begin
         root_in = payoff;
      end
      // The last write to node zero is the root of the tree.
      if (cmd.fold_store && node_addr == '0) begin
         root_in = prod_ff[61:30];
      end
   end

   always_ff @(posedge clock) begin
      spot_ff <= spot_in;
      x_ff    <= x_in;
      sat_ff  <= sat_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
   end

   assign ram_we  = cmd.leaf_store | cmd.fold_store;
   assign ram_wd  = cmd.fold_store ? prod_ff[61:30] : payoff;
   assign rd_addr = cmd.rd_hi ? node_addr + AW'(1) : node_addr;

   btop_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_nodes (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(node_addr),
      .wr_data(ram_wd),
      .rd_addr(rd_addr),
      .rd_data(ram_rd)
   );

   assign root_value = root_ff;
   assign sat_flag   = sat_ff;
endmodule

// ----- rtl/btop_ctrl.sv -----
`timescale 1ns / 1ps
module btop_ctrl #(
   parameter int unsigned MAX_STEPS = btop_pkg::MAX_STEPS_DEFAULT,
   localparam int unsigned AW = $clog2(MAX_STEPS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [7:0]           steps_cfg,
   input  logic                 out_taken,
   output logic                 busy,
   output logic                 done,
   output logic [AW-1:0]        node_addr,
   output btop_pkg::dp_cmd_type cmd
);
   btop_pkg::state_type state_ff, state_in;
   logic [AW-1:0] n_ff, n_in;
   logic [AW-1:0] leaf_ff, leaf_in;     // leaf index i
   logic [AW-1:0] cnt_ff, cnt_in;       // multiplies done for this leaf
   logic [AW-1:0] step_ff, step_in;     // current fold width
   logic [AW-1:0] node_ff, node_in;
   logic [AW:0]   steps_wide;
   logic [AW-1:0] steps_c;

   assign steps_wide = (AW + 1)'(steps_cfg);
   assign steps_c = (steps_wide > (AW + 1)'(MAX_STEPS)) ? AW'(MAX_STEPS)
                                                         : steps_wide[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      leaf_in    = leaf_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      node_in    = node_ff;
      unique case (state_ff)
         btop_pkg::ST_IDLE: begin
            if (start) begin
               n_in    = steps_c;
               leaf_in = '0;
               cnt_in  = '0;
               node_in = '0;
               state_in = (steps_c == '0) ? btop_pkg::ST_ZERO
                                          : btop_pkg::ST_LEAF_MUL;
            end
         end
         btop_pkg::ST_LEAF_MUL: state_in = btop_pkg::ST_LEAF_TAKE;
         btop_pkg::ST_LEAF_TAKE: begin
            if (cnt_ff + AW'(1) == n_ff) begin
               cnt_in   = '0;
               state_in = btop_pkg::ST_LEAF_STORE;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = btop_pkg::ST_LEAF_MUL;
            end
         end
         btop_pkg::ST_LEAF_STORE: begin
            if (leaf_ff == n_ff) begin
               step_in  = n_ff;
               node_in  = '0;
               state_in = btop_pkg::ST_FOLD_RD0;
            end else begin
               leaf_in  = leaf_ff + AW'(1);
               node_in  = leaf_ff + AW'(1);
               state_in = btop_pkg::ST_LEAF_MUL;
            end
         end
         btop_pkg::ST_FOLD_RD0:   state_in = btop_pkg::ST_FOLD_RD1;
         btop_pkg::ST_FOLD_RD1:   state_in = btop_pkg::ST_FOLD_MUL_Q;
         btop_pkg::ST_FOLD_MUL_Q: state_in = btop_pkg::ST_FOLD_MUL_D;
         btop_pkg::ST_FOLD_MUL_D: state_in = btop_pkg::ST_FOLD_STORE;
         btop_pkg::ST_FOLD_STORE: begin
            if (node_ff + AW'(1) == step_ff) begin
               node_in = '0;
               if (step_ff == AW'(1)) begin
                  state_in = btop_pkg::ST_DONE;
               end else begin
                  step_in  = step_ff - AW'(1);
                  state_in = btop_pkg::ST_FOLD_RD0;
               end
            end else begin
               node_in  = node_ff + AW'(1);
               state_in = btop_pkg::ST_FOLD_RD0;
            end
         end
         btop_pkg::ST_ZERO: state_in = btop_pkg::ST_DONE;
         btop_pkg::ST_DONE: begin
            if (out_taken) begin
               state_in = btop_pkg::ST_IDLE;
            end
         end
         default: state_in = btop_pkg::ST_IDLE;
      endcase
   end

   // Outputs. The RAM read of node i issued in FOLD_RD0 is seen in FOLD_RD1,
   // and that of node i+1 issued in FOLD_RD1 is seen in FOLD_MUL_Q.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      unique case (state_ff)
         btop_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.load_spot = start;
         end
         btop_pkg::ST_LEAF_MUL: begin
            cmd.leaf_mul = 1'b1;
            cmd.use_down = (cnt_ff >= n_ff - leaf_ff);
         end
         btop_pkg::ST_LEAF_TAKE:  cmd.leaf_take = 1'b1;
         btop_pkg::ST_LEAF_STORE: cmd.leaf_store = 1'b1;
         btop_pkg::ST_FOLD_RD0:   ;
         btop_pkg::ST_FOLD_RD1: begin
            cmd.rd_hi = 1'b1;
            cmd.mul_p = 1'b1;
         end
         btop_pkg::ST_FOLD_MUL_Q: cmd.mul_q = 1'b1;
         btop_pkg::ST_FOLD_MUL_D: cmd.mul_d = 1'b1;
         btop_pkg::ST_FOLD_STORE: cmd.fold_store = 1'b1;
         btop_pkg::ST_ZERO:       cmd.zero_steps = 1'b1;
         btop_pkg::ST_DONE:       done = 1'b1;
         default: ;
      endcase
   end

   assign node_addr = node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btop_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff    <= n_in;
      leaf_ff <= leaf_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      node_ff <= node_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == btop_pkg::ST_FOLD_MUL_Q) |-> $past(state_ff) == btop_pkg::ST_FOLD_RD1)
      else $error("fold multiply without preceding read");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != btop_pkg::ST_IDLE && state_ff != btop_pkg::ST_DONE) |-> node_ff <= n_ff)
      else $error("node address beyond tree width");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.leaf_store, cmd.fold_store}))
      else $error("two node writes in one cycle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == btop_pkg::ST_DONE && !out_taken) |=> state_ff == btop_pkg::ST_DONE)
      else $error("result dropped before transfer");
endmodule

// ----- rtl/binomial_tree_option_pricer.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Transfer condition        Payload
// req       in         req_valid & req_ready     req_spot_price
// rsp       out        rsp_valid & rsp_ready     rsp_price, rsp_saturated
// csr       in         csr_write                 csr_index, csr_data
// One item at a time; req_ready is high only when idle and the shared multiplier sets the rate.
// Each leaf takes N multiplies of the spot, saturated, before its store; the fold then reads,
// weights, discounts and stores the N*(N+1)/2 nodes in turn, and N = 0 takes the payoff directly.
// Reset is synchronous and resets the controller state and the configuration registers; the
// datapath and node store hold none. A stalled result holds the block until it is taken.
module binomial_tree_option_pricer #(
   parameter int unsigned MAX_STEPS = btop_pkg::MAX_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_spot_price,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_price,
   output logic        rsp_saturated,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int unsigned AW = $clog2(MAX_STEPS + 1);

   logic [31:0] strike_ff, up_ff, down_ff;
   logic [30:0] prob_ff, disc_ff;
   logic [7:0]  steps_ff;
   logic        put_ff;
   logic        busy, done;
   logic [AW-1:0] node_addr;
   btop_pkg::dp_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         strike_ff <= '0;
         up_ff     <= 32'h4000_0000;
         down_ff   <= 32'h4000_0000;
         prob_ff   <= 31'h2000_0000;
         disc_ff   <= btop_pkg::ONE_Q30;
         steps_ff  <= 8'd1;
         put_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            btop_pkg::CSR_STRIKE: strike_ff <= csr_data;
            btop_pkg::CSR_UP:     up_ff     <= csr_data;
            btop_pkg::CSR_DOWN:   down_ff   <= csr_data;
            btop_pkg::CSR_PROB:   prob_ff   <= csr_data[30:0];
            btop_pkg::CSR_DISC:   disc_ff   <= csr_data[30:0];
            btop_pkg::CSR_STEPS:  steps_ff  <= csr_data[7:0];
            btop_pkg::CSR_IS_PUT: put_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_ready = !busy;
   assign rsp_valid = done;

   btop_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .steps_cfg(steps_ff),
      .out_taken(rsp_ready),
      .busy     (busy),
      .done     (done),
      .node_addr(node_addr),
      .cmd      (cmd)
   );

   btop_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .node_addr  (node_addr),
      .spot       (req_spot_price),
      .strike     (strike_ff),
      .up_factor  (up_ff),
      .down_factor(down_ff),
      .prob       (prob_ff),
      .disc       (disc_ff),
      .is_put     (put_ff),
      .root_value (rsp_price),
      .sat_flag   (rsp_saturated)
   );
endmodule
